@@ design/tiew_pkg.sv @@
// Package for the Tomasulo issue/execute/writeback block: payload structs, codes,
// and the command/status structs that join the controller and the datapath.
// No dependencies.
`default_nettype none
package tiew_pkg;

    // Operation codes carried by an input item.
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_LOAD = 3'd4;

    // Input function codes.
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_PRELOAD = 1'b1;

    // Result kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WB     = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ADD_LAT = 2'd0;
    localparam logic [1:0] CFG_MUL_LAT = 2'd1;
    localparam logic [1:0] CFG_DIV_LAT = 2'd2;
    localparam logic [1:0] CFG_LD_LAT  = 2'd3;

    typedef struct packed {
        logic        func;
        logic        issue_valid;
        logic [2:0]  op;
        logic [3:0]  dest_reg;
        logic [3:0]  src1_reg;
        logic [3:0]  src2_reg;
        logic [31:0] immediate;
        logic [3:0]  preload_index;
        logic [31:0] preload_value;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic        issue_accepted;
        logic [2:0]  issued_station;
        logic [15:0] issued_tag;
        logic [2:0]  wb_station;
        logic [15:0] wb_tag;
        logic [31:0] wb_value;
        logic        reg_written_valid;
        logic [3:0]  reg_written;
        logic        last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick;       // run issue and execute, emit status result
        logic preload;    // write a register
        logic wb_step;    // broadcast the selected pending station
        logic div_start;  // start the divider on the selected station
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wb_any;     // a station waits to broadcast
        logic wb_more;    // more than one station waits to broadcast
        logic div_need;   // a divide wants its quotient computed
        logic div_done;   // divider finished
    } stat_t;

endpackage
`default_nettype wire

@@ design/tiew_div.sv @@
// Radix-2 signed divider, one quotient bit per cycle.
// Depends on nothing but its ports.
`default_nettype none
module tiew_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic [32:0] trial;

    // Shift-subtract step on magnitudes; sign is fixed up at the end.
    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        done      = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = 32'd0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            den_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            zero_next = (divisor == 32'd0);
        end else if (busy_reg) begin
            if (cnt_reg == 6'd32) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end else begin
                cnt_next = cnt_reg + 6'd1;
                if (!trial[32]) begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
            end
        end
    end

    // Most negative over minus one falls out of the wrap naturally.
    assign quotient = zero_reg ? 32'd0 : (neg_reg ? (32'd0 - quo_reg) : quo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end
endmodule
`default_nettype wire

@@ design/tiew_datapath.sv @@
// Datapath: reservation stations, register file, rename table, issue and
// execute logic, and the writeback broadcast. Depends on tiew_pkg, tiew_div.
`default_nettype none
module tiew_datapath #(
    parameter int NUM_ADD_STATIONS  = 3,
    parameter int NUM_MUL_STATIONS  = 2,
    parameter int NUM_LOAD_STATIONS = 3,
    parameter int NUM_REGS          = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire tiew_pkg::in_item_t item,
    input  wire tiew_pkg::cmd_t     cmd,
    input  wire logic [7:0]         add_lat,
    input  wire logic [7:0]         mul_lat,
    input  wire logic [7:0]         div_lat,
    input  wire logic [7:0]         ld_lat,
    output tiew_pkg::stat_t         stat,
    output tiew_pkg::out_item_t     status_item,
    output tiew_pkg::out_item_t     wb_item
);
    localparam int NS = NUM_ADD_STATIONS + NUM_MUL_STATIONS + NUM_LOAD_STATIONS;
    localparam logic [3:0] Q_AVAIL = 4'(NS);
    localparam logic [3:0] Q_INIT  = 4'(NS + 1);
    localparam int MLO = NUM_ADD_STATIONS;
    localparam int LLO = NUM_ADD_STATIONS + NUM_MUL_STATIONS;

    logic        busy_reg [NS];
    logic [2:0]  sop_reg  [NS];
    logic [31:0] vj_reg   [NS];
    logic [31:0] vk_reg   [NS];
    logic [3:0]  qj_reg   [NS];
    logic [3:0]  qk_reg   [NS];
    logic [7:0]  cnt_reg  [NS];
    logic        iw_reg   [NS];
    logic [31:0] res_reg  [NS];
    logic        rdy_reg  [NS];
    logic        wbw_reg  [NS];
    logic [15:0] tag_reg  [NS];
    logic        dvd_reg  [NS];  // quotient held in res_reg for a divide
    logic [31:0] rf_reg   [NUM_REGS];
    logic [3:0]  rs_reg   [NUM_REGS];
    logic [15:0] icount_reg;

    // Issue: find lowest free station of the class.
    logic       acc;
    logic [2:0] ist;
    logic       op_ok;
    always_comb begin
        int lo, hi;
        lo = 0; hi = 0;
        acc = 1'b0;
        ist = 3'd0;
        op_ok = item.issue_valid && (item.op <= tiew_pkg::OP_LOAD);
        if (item.op <= tiew_pkg::OP_SUB) begin
            lo = 0; hi = MLO;
        end else if (item.op <= tiew_pkg::OP_DIV) begin
            lo = MLO; hi = LLO;
        end else begin
            lo = LLO; hi = NS;
        end
        for (int r = NS - 1; r >= 0; r--) begin
            if (op_ok && r >= lo && r < hi && !busy_reg[r]) begin
                acc = 1'b1;
                ist = 3'(r);
            end
        end
    end

    // Source operand read with renaming.
    logic [31:0] s1v, s2v;
    logic [3:0]  s1q, s2q;
    always_comb begin
        s1v = 32'd0; s1q = Q_AVAIL;
        s2v = 32'd0; s2q = Q_AVAIL;
        if (32'(item.src1_reg) < NUM_REGS) begin
            if (rs_reg[item.src1_reg] != Q_AVAIL) s1q = rs_reg[item.src1_reg];
            else s1v = rf_reg[item.src1_reg];
        end
        if (32'(item.src2_reg) < NUM_REGS) begin
            if (rs_reg[item.src2_reg] != Q_AVAIL) s2q = rs_reg[item.src2_reg];
            else s2v = rf_reg[item.src2_reg];
        end
    end

    // Writeback selection: lowest station pending broadcast.
    logic       wb_any;
    logic [2:0] wsel;
    logic [3:0] npend;
    always_comb begin
        wb_any = 1'b0; wsel = 3'd0; npend = 4'd0;
        for (int r = NS - 1; r >= 0; r--) begin
            if (rdy_reg[r] && wbw_reg[r]) begin
                wb_any = 1'b1;
                wsel = 3'(r);
            end
        end
        for (int r = 0; r < NS; r++) npend = npend + 4'(rdy_reg[r] && wbw_reg[r]);
    end

    logic       rv;
    logic [3:0] rw;
    always_comb begin
        rv = 1'b0; rw = 4'd0;
        for (int x = NUM_REGS - 1; x >= 0; x--) begin
            if (rs_reg[x] == 4'(wsel)) begin
                rv = 1'b1;
                rw = 4'(x);
            end
        end
    end

    // Divide requests: station whose divide has arrived but has no quotient.
    logic       div_need;
    logic [2:0] dsel;
    always_comb begin
        div_need = 1'b0; dsel = 3'd0;
        for (int r = NS - 1; r >= 0; r--) begin
            if (busy_reg[r] && sop_reg[r] == tiew_pkg::OP_DIV && !dvd_reg[r]
                && qj_reg[r] == Q_AVAIL && qk_reg[r] == Q_AVAIL) begin
                div_need = 1'b1;
                dsel = 3'(r);
            end
        end
    end

    logic [2:0]  dsel_reg;
    logic        ddone;
    logic [31:0] dquo;
    tiew_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (vj_reg[dsel]),
        .divisor  (vk_reg[dsel]),
        .done     (ddone),
        .quotient (dquo)
    );

    assign stat.wb_any   = wb_any;
    assign stat.wb_more  = (npend > 4'd1);
    assign stat.div_need = div_need;
    assign stat.div_done = ddone;

    always_comb begin
        status_item = '0;
        status_item.kind = tiew_pkg::KIND_STATUS;
        status_item.issue_accepted = acc;
        status_item.issued_station = acc ? ist : 3'd0;
        status_item.issued_tag = acc ? icount_reg : 16'd0;
        wb_item = '0;
        wb_item.kind = tiew_pkg::KIND_WB;
        wb_item.wb_station = wsel;
        wb_item.wb_tag = tag_reg[wsel];
        wb_item.wb_value = res_reg[wsel];
        wb_item.reg_written_valid = rv;
        wb_item.reg_written = rw;
    end

    // Per-station execute step result for the tick.
    function automatic logic [31:0] alu(input logic [2:0] o, input logic [31:0] a,
                                        input logic [31:0] b);
        logic [31:0] r;
        unique case (o)
            tiew_pkg::OP_ADD: r = a + b;
            tiew_pkg::OP_SUB: r = a - b;
            tiew_pkg::OP_MUL: r = a * b;
            default:          r = a;
        endcase
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NS; r++) begin
                busy_reg[r] <= 1'b0; sop_reg[r] <= 3'd0;
                vj_reg[r] <= 32'd0; vk_reg[r] <= 32'd0;
                qj_reg[r] <= Q_INIT; qk_reg[r] <= Q_INIT;
                cnt_reg[r] <= 8'd0; iw_reg[r] <= 1'b0;
                res_reg[r] <= 32'd0; rdy_reg[r] <= 1'b0;
                wbw_reg[r] <= 1'b0; tag_reg[r] <= 16'd0; dvd_reg[r] <= 1'b0;
            end
            for (int x = 0; x < NUM_REGS; x++) begin
                rf_reg[x] <= 32'd0; rs_reg[x] <= Q_AVAIL;
            end
            icount_reg <= 16'd0;
            dsel_reg <= 3'd0;
        end else begin
            if (cmd.div_start) dsel_reg <= dsel;
            if (ddone) begin
                res_reg[dsel_reg] <= dquo;
                dvd_reg[dsel_reg] <= 1'b1;
            end
            if (cmd.preload) begin
                if (32'(item.preload_index) < NUM_REGS)
                    rf_reg[item.preload_index] <= item.preload_value;
            end
            if (cmd.tick) begin
                // Execute on state before this tick's issue.
                for (int r = 0; r < NS; r++) begin
                    logic [7:0] lat;
                    logic [7:0] c1;
                    lat = add_lat; c1 = cnt_reg[r] + 8'd1;
                    unique case (sop_reg[r])
                        tiew_pkg::OP_MUL:  lat = mul_lat;
                        tiew_pkg::OP_DIV:  lat = div_lat;
                        tiew_pkg::OP_LOAD: lat = ld_lat;
                        default:           lat = add_lat;
                    endcase
                    if (busy_reg[r] && !(acc && 3'(r) == ist)) begin
                        if (!iw_reg[r]) iw_reg[r] <= 1'b1;
                        else if (qj_reg[r] == Q_AVAIL && (qk_reg[r] == Q_AVAIL
                                 || sop_reg[r] == tiew_pkg::OP_LOAD)) begin
                            cnt_reg[r] <= c1;
                            if (c1 == lat) begin
                                if (sop_reg[r] != tiew_pkg::OP_DIV)
                                    res_reg[r] <= alu(sop_reg[r], vj_reg[r], vk_reg[r]);
                                rdy_reg[r] <= 1'b1;
                                cnt_reg[r] <= 8'd0;
                                iw_reg[r] <= 1'b0;
                            end
                        end
                    end
                    if (rdy_reg[r] && !wbw_reg[r]) wbw_reg[r] <= 1'b1;
                end
                if (acc) begin
                    sop_reg[ist] <= item.op;
                    busy_reg[ist] <= 1'b1;
                    iw_reg[ist] <= 1'b1;
                    tag_reg[ist] <= icount_reg;
                    dvd_reg[ist] <= 1'b0;
                    cnt_reg[ist] <= 8'd0;
                    icount_reg <= icount_reg + 16'd1;
                    if (item.op == tiew_pkg::OP_LOAD) begin
                        vj_reg[ist] <= item.immediate;
                        qj_reg[ist] <= Q_AVAIL; qk_reg[ist] <= Q_AVAIL;
                    end else begin
                        vj_reg[ist] <= s1v; qj_reg[ist] <= s1q;
                        vk_reg[ist] <= s2v; qk_reg[ist] <= s2q;
                    end
                    if (32'(item.dest_reg) < NUM_REGS) rs_reg[item.dest_reg] <= 4'(ist);
                end
            end
            if (cmd.wb_step) begin
                for (int x = 0; x < NUM_REGS; x++) begin
                    if (rs_reg[x] == 4'(wsel)) begin
                        rf_reg[x] <= res_reg[wsel];
                        rs_reg[x] <= Q_AVAIL;
                    end
                end
                for (int y = 0; y < NS; y++) begin
                    if (qj_reg[y] == 4'(wsel)) begin
                        vj_reg[y] <= res_reg[wsel]; qj_reg[y] <= Q_AVAIL;
                    end
                    if (qk_reg[y] == 4'(wsel)) begin
                        vk_reg[y] <= res_reg[wsel]; qk_reg[y] <= Q_AVAIL;
                    end
                end
                rdy_reg[wsel] <= 1'b0; busy_reg[wsel] <= 1'b0;
                wbw_reg[wsel] <= 1'b0; dvd_reg[wsel] <= 1'b0;
                qj_reg[wsel] <= Q_INIT; qk_reg[wsel] <= Q_INIT;
                vj_reg[wsel] <= 32'd0; vk_reg[wsel] <= 32'd0;
            end
        end
    end
endmodule
`default_nettype wire

@@ design/tiew_ctrl.sv @@
// Controller state machine: sequences divides, issue/execute, status and
// writeback results. Depends on tiew_pkg.
`default_nettype none
module tiew_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_func,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                sel_wb,
    output logic                out_last,
    input  wire tiew_pkg::stat_t stat,
    output tiew_pkg::cmd_t      cmd
);
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIV    = 5'b00010,
        ST_STATUS = 5'b00100,
        ST_WB     = 5'b01000,
        ST_DWAIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Divides are resolved before a tick so their quotient is ready at finish.
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        sel_wb = 1'b0;
        out_last = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (stat.div_need) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DWAIT;
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        if (s_func == tiew_pkg::FUNC_PRELOAD) cmd.preload = 1'b1;
                        else begin
                            cmd.tick = 1'b1;
                            state_next = ST_STATUS;
                        end
                    end
                end
            end
            ST_DWAIT: begin
                if (stat.div_done) state_next = ST_IDLE;
            end
            ST_STATUS: begin
                m_valid = 1'b1;
                out_last = !stat.wb_any;
                if (m_ready) state_next = stat.wb_any ? ST_WB : ST_IDLE;
            end
            ST_WB: begin
                m_valid = 1'b1;
                sel_wb = 1'b1;
                out_last = !stat.wb_more;
                if (m_ready) begin
                    cmd.wb_step = 1'b1;
                    if (!stat.wb_more) state_next = ST_IDLE;
                end
            end
            ST_DIV: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

@@ design/tomasulo_issue_execute_writeback.sv @@
// Tomasulo issue/execute/writeback core, top level.
// Depends on tiew_pkg, tiew_ctrl, tiew_datapath.
//
// Usage: s_ carries one input item per transfer (a tick with an optional
// instruction, or a register preload). m_ returns, for each tick, one status
// result and then one writeback result per broadcasting station, the final one
// flagged by last. Preloads return nothing.
// cfg_ writes the four latency registers, one per value of the two-bit cfg_index.
// Timing: a tick is accepted in the idle state, then its status result and its
// writeback results are emitted one after another. A tick that arrives while
// an issued divide has its operands ready first waits for the bit-serial
// divider, once per divide. Output is held in place while m_ready
// is low; no new item is taken until the tick's last result is transferred.
// Reset (synchronous, active low) frees all stations, clears the register
// file and the rename table, and restores the default latencies.
`default_nettype none
module tomasulo_issue_execute_writeback #(
    parameter int NUM_ADD_STATIONS  = 3,
    parameter int NUM_MUL_STATIONS  = 2,
    parameter int NUM_LOAD_STATIONS = 3,
    parameter int NUM_REGS          = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tiew_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tiew_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [7:0]          cfg_data
);
    logic [7:0] add_lat_reg, mul_lat_reg, div_lat_reg, ld_lat_reg;
    tiew_pkg::cmd_t      cmd;
    tiew_pkg::stat_t     stat;
    tiew_pkg::out_item_t status_item, wb_item;
    logic sel_wb, out_last;

    assign cfg_ready = 1'b1;

    // Latency registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_lat_reg <= 8'd2; mul_lat_reg <= 8'd10;
            div_lat_reg <= 8'd40; ld_lat_reg <= 8'd2;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tiew_pkg::CFG_ADD_LAT: add_lat_reg <= cfg_data;
                tiew_pkg::CFG_MUL_LAT: mul_lat_reg <= cfg_data;
                tiew_pkg::CFG_DIV_LAT: div_lat_reg <= cfg_data;
                tiew_pkg::CFG_LD_LAT:  ld_lat_reg  <= cfg_data;
            endcase
        end
    end

    tiew_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_func(s_data.func), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .sel_wb(sel_wb), .out_last(out_last), .stat(stat), .cmd(cmd)
    );

    tiew_datapath #(
        .NUM_ADD_STATIONS(NUM_ADD_STATIONS), .NUM_MUL_STATIONS(NUM_MUL_STATIONS),
        .NUM_LOAD_STATIONS(NUM_LOAD_STATIONS), .NUM_REGS(NUM_REGS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .item(s_data), .cmd(cmd),
        .add_lat(add_lat_reg), .mul_lat(mul_lat_reg),
        .div_lat(div_lat_reg), .ld_lat(ld_lat_reg),
        .stat(stat), .status_item(status_item), .wb_item(wb_item)
    );

    // Status result is held in a register, since the datapath moves on.
    tiew_pkg::out_item_t st_reg;
    always_ff @(posedge aclk) begin
        if (cmd.tick) st_reg <= status_item;
    end

    always_comb begin
        m_data = sel_wb ? wb_item : st_reg;
        m_data.last = out_last;
    end

    // Ticks and writeback steps never coincide.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.tick && cmd.wb_step)) else $error("tick during writeback");
    // No input transfer while a result is offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while output pending");
    // A tick transfer is followed by a status result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick |=> (m_valid && m_data.kind == tiew_pkg::KIND_STATUS))
        else $error("status result missing");
endmodule
`default_nettype wire
